// ===== hdl/citc_pkg.sv =====
`timescale 1ns / 1ps
package citc_pkg;

  localparam int YearBase   = 1970;
  localparam int YearSpan   = 130;
  localparam int CenturyOff = 2100 - YearBase;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int AccW  = 35;
  localparam int DivW  = 34;
  localparam int CntW  = $clog2(DivW + 1);
  localparam int PerW  = 31;
  localparam int TickW = 32;
  localparam int DayW  = 18;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdEnd   = 1'b1;

  typedef enum logic [2:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR,
    UNIT_DAY,
    UNIT_MONTH,
    UNIT_YEAR
  } unit_t;

  typedef struct packed {
    unit_t             unit;
    logic [7:0]        e_year;
    logic [3:0]        e_month;
    logic [4:0]        e_day;
    logic [4:0]        e_hour;
    logic [5:0]        e_minute;
    logic [5:0]        e_second;
    logic [7:0]        s_year;
    logic [4:0]        s_month;
    logic [5:0]        s_day;
    logic [5:0]        s_hour;
    logic [6:0]        s_minute;
    logic [5:0]        s_second;
    logic [PerW-1:0]   period;
  } job_t;

  function automatic logic [8:0] days_before_month(logic [3:0] mc);
    logic [8:0] r;
    unique case (mc)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // days since the epoch, day of month counted linearly
  function automatic logic signed [DayW-1:0] day_count(logic [7:0] yoff, logic [4:0] mon,
                                                       logic [5:0] day);
    logic [3:0]      mc;
    logic [7:0]      leaps;
    logic            leap;
    logic [DayW-1:0] base;
    if (mon < 5'd1) begin
      mc = 4'd1;
    end else if (mon > 5'd12) begin
      mc = 4'd12;
    end else begin
      mc = mon[3:0];
    end
    leaps = 8'((9'(yoff) + 9'd1) >> 2) - ((yoff > 8'(CenturyOff)) ? 8'd1 : 8'd0);
    leap  = (yoff[1:0] == 2'd2) && (yoff != 8'(CenturyOff));
    base  = DayW'(yoff) * DayW'(365) + DayW'(leaps) + DayW'(days_before_month(mc))
          + ((mc > 4'd2 && leap) ? DayW'(1) : DayW'(0));
    return $signed(base + DayW'(day)) - $signed(DayW'(1));
  endfunction

endpackage

// ===== hdl/citc_front.sv =====
`timescale 1ns / 1ps
module citc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [11:0]             in_year,
  input  logic [3:0]              in_month,
  input  logic [4:0]              in_day,
  input  logic [4:0]              in_hour,
  input  logic [5:0]              in_minute,
  input  logic [5:0]              in_second,
  input  logic [2:0]              in_unit,
  input  logic [citc_pkg::PerW-1:0] in_period,
  input  logic                    q_full,
  output logic                    push,
  output citc_pkg::job_t          push_job
);

  logic [7:0] start_year_r;
  logic [3:0] start_month_r;
  logic [4:0] start_day_r;
  logic [4:0] start_hour_r;
  logic [5:0] start_minute_r;
  logic [5:0] start_second_r;

  logic            accept;
  logic [7:0]      yoff;
  citc_pkg::unit_t unit;
  logic            frac_sec, frac_min, frac_hour, frac_day, frac_month;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (in_cmd == citc_pkg::CmdEnd);

  always_comb begin
    if (in_year < 12'(citc_pkg::YearBase)) begin
      yoff = 8'd0;
    end else if (in_year - 12'(citc_pkg::YearBase) > 12'(citc_pkg::YearSpan - 1)) begin
      yoff = 8'(citc_pkg::YearSpan - 1);
    end else begin
      yoff = 8'(in_year - 12'(citc_pkg::YearBase));
    end
  end

  assign unit = (in_unit > 3'(citc_pkg::UNIT_YEAR)) ? citc_pkg::UNIT_YEAR
                                                    : citc_pkg::unit_t'(in_unit);

  assign frac_sec   = (start_second_r != 6'd0);
  assign frac_min   = frac_sec || (start_minute_r != 6'd0);
  assign frac_hour  = frac_min || (start_hour_r != 5'd0);
  assign frac_day   = frac_hour || (start_day_r != 5'd1);
  assign frac_month = frac_day || (start_month_r != 4'd1);

  // round the stored start up to the next boundary of the unit
  always_comb begin
    push_job          = '0;
    push_job.unit     = unit;
    push_job.e_year   = yoff;
    push_job.e_month  = in_month;
    push_job.e_day    = in_day;
    push_job.e_hour   = in_hour;
    push_job.e_minute = in_minute;
    push_job.e_second = in_second;
    push_job.period   = (in_period == '0) ? citc_pkg::PerW'(1) : in_period;
    push_job.s_year   = start_year_r;
    push_job.s_month  = 5'(start_month_r);
    push_job.s_day    = 6'(start_day_r);
    push_job.s_hour   = 6'(start_hour_r);
    push_job.s_minute = 7'(start_minute_r);
    push_job.s_second = start_second_r;
    unique case (unit)
      citc_pkg::UNIT_SEC: begin
      end
      citc_pkg::UNIT_MIN: begin
        if (frac_sec) push_job.s_minute = 7'(start_minute_r) + 7'd1;
      end
      citc_pkg::UNIT_HOUR: begin
        if (frac_min) push_job.s_hour = 6'(start_hour_r) + 6'd1;
      end
      citc_pkg::UNIT_DAY: begin
        if (frac_hour) push_job.s_day = 6'(start_day_r) + 6'd1;
      end
      citc_pkg::UNIT_MONTH: begin
        if (frac_day) push_job.s_month = 5'(start_month_r) + 5'd1;
      end
      default: begin
        if (frac_month) push_job.s_year = start_year_r + 8'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r   <= '0;
      start_month_r  <= '0;
      start_day_r    <= '0;
      start_hour_r   <= '0;
      start_minute_r <= '0;
      start_second_r <= '0;
    end else if (accept && (in_cmd == citc_pkg::CmdStart)) begin
      start_year_r   <= yoff;
      start_month_r  <= in_month;
      start_day_r    <= in_day;
      start_hour_r   <= in_hour;
      start_minute_r <= in_minute;
      start_second_r <= in_second;
    end
  end

endmodule

// ===== hdl/citc_queue.sv =====
`timescale 1ns / 1ps
module citc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  citc_pkg::job_t push_job,
  input  logic           pop,
  output citc_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  citc_pkg::job_t                  mem_r [citc_pkg::QueueDepth];
  logic [citc_pkg::QPtrW-1:0]      wr_ptr_r;
  logic [citc_pkg::QPtrW-1:0]      rd_ptr_r;
  logic [citc_pkg::QCntW-1:0]      count_r;

  assign full  = (count_r == citc_pkg::QCntW'(citc_pkg::QueueDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [citc_pkg::QPtrW-1:0] advance(logic [citc_pkg::QPtrW-1:0] p);
    return (p == citc_pkg::QPtrW'(citc_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= advance(wr_ptr_r);
      if (pop) rd_ptr_r <= advance(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= citc_pkg::QCntW'(citc_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

// ===== hdl/citc_back.sv =====
`timescale 1ns / 1ps
module citc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  citc_pkg::job_t             head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [citc_pkg::TickW-1:0] out_tick_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_DIFF,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                           st_r;
  citc_pkg::job_t                   job_r;
  logic signed [citc_pkg::AccW-1:0] acc_a_r;
  logic signed [citc_pkg::AccW-1:0] acc_b_r;
  logic [citc_pkg::DivW-1:0]        q_r;
  logic [citc_pkg::PerW-1:0]        rem_r;
  logic [citc_pkg::PerW-1:0]        div_r;
  logic [citc_pkg::CntW-1:0]        cnt_r;
  logic                             out_valid_r;
  logic [citc_pkg::TickW-1:0]       out_tick_count_r;

  logic signed [citc_pkg::AccW-1:0] base_a;
  logic signed [citc_pkg::AccW-1:0] base_b;
  logic signed [citc_pkg::AccW-1:0] diff;
  logic [citc_pkg::PerW:0]          trial;
  logic                             ge;

  assign pop            = (st_r == ST_IDLE) && !empty;
  assign out_valid      = out_valid_r;
  assign out_tick_count = out_tick_count_r;

  always_comb begin
    unique case (head.unit)
      citc_pkg::UNIT_MONTH: begin
        base_a = $signed(citc_pkg::AccW'(head.e_year) * citc_pkg::AccW'(12)
                         + citc_pkg::AccW'(head.e_month)) - $signed(citc_pkg::AccW'(1));
        base_b = $signed(citc_pkg::AccW'(head.s_year) * citc_pkg::AccW'(12)
                         + citc_pkg::AccW'(head.s_month)) - $signed(citc_pkg::AccW'(1));
      end
      citc_pkg::UNIT_YEAR: begin
        base_a = $signed(citc_pkg::AccW'(head.e_year));
        base_b = $signed(citc_pkg::AccW'(head.s_year));
      end
      default: begin
        base_a = citc_pkg::AccW'(citc_pkg::day_count(head.e_year, 5'(head.e_month),
                                                      6'(head.e_day)));
        base_b = citc_pkg::AccW'(citc_pkg::day_count(head.s_year, head.s_month,
                                                      head.s_day));
      end
    endcase
  end

  assign diff  = acc_a_r - acc_b_r;
  assign trial = {rem_r, q_r[citc_pkg::DivW-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (st_r != ST_DONE)) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (!empty) begin
            job_r   <= head;
            acc_a_r <= base_a;
            acc_b_r <= base_b;
            if (head.unit == citc_pkg::UNIT_SEC || head.unit == citc_pkg::UNIT_MIN ||
                head.unit == citc_pkg::UNIT_HOUR) begin
              st_r <= ST_HOUR;
            end else begin
              st_r <= ST_DIFF;
            end
          end
        end
        ST_HOUR: begin
          acc_a_r <= acc_a_r * $signed(citc_pkg::AccW'(24))
                   + $signed(citc_pkg::AccW'(job_r.e_hour));
          acc_b_r <= acc_b_r * $signed(citc_pkg::AccW'(24))
                   + $signed(citc_pkg::AccW'(job_r.s_hour));
          st_r    <= (job_r.unit == citc_pkg::UNIT_HOUR) ? ST_DIFF : ST_MIN;
        end
        ST_MIN: begin
          acc_a_r <= acc_a_r * $signed(citc_pkg::AccW'(60))
                   + $signed(citc_pkg::AccW'(job_r.e_minute));
          acc_b_r <= acc_b_r * $signed(citc_pkg::AccW'(60))
                   + $signed(citc_pkg::AccW'(job_r.s_minute));
          st_r    <= (job_r.unit == citc_pkg::UNIT_MIN) ? ST_DIFF : ST_SEC;
        end
        ST_SEC: begin
          acc_a_r <= acc_a_r * $signed(citc_pkg::AccW'(60))
                   + $signed(citc_pkg::AccW'(job_r.e_second));
          acc_b_r <= acc_b_r * $signed(citc_pkg::AccW'(60))
                   + $signed(citc_pkg::AccW'(job_r.s_second));
          st_r    <= ST_DIFF;
        end
        ST_DIFF: begin
          div_r <= job_r.period;
          rem_r <= '0;
          cnt_r <= citc_pkg::CntW'(citc_pkg::DivW);
          if (diff > $signed(citc_pkg::AccW'(0))) begin
            q_r  <= diff[citc_pkg::DivW-1:0];
            st_r <= ST_DIV;
          end else begin
            q_r  <= '0;
            st_r <= ST_DONE;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? citc_pkg::PerW'(trial - {1'b0, div_r}) : trial[citc_pkg::PerW-1:0];
          q_r   <= {q_r[citc_pkg::DivW-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == citc_pkg::CntW'(1)) st_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_tick_count_r <= (|q_r[citc_pkg::DivW-1:citc_pkg::TickW]) ? '1
                                : q_r[citc_pkg::TickW-1:0];
            st_r             <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> rem_r < div_r)
    else $error("divider remainder not below divisor");
  a_nonpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && $past(st_r) == ST_DIFF) |-> q_r == '0)
    else $error("non-positive interval must give zero");
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> st_r != ST_IDLE)
    else $error("popped job not started");

endmodule

// ===== hdl/calendar_interval_tick_counter.sv =====
`timescale 1ns / 1ps
// Counts whole periods between a stored start timestamp and an end timestamp.
// A start transfer (cmd 0) is stored in the start registers and gives no result. An end
// transfer (cmd 1) is paired with the rounded start and queued in the same cycle; the
// queue holds two end items. The back end then takes one item at a time: it forms day,
// month or year counts as it takes the item, scales them to hours, minutes and seconds
// as far as the unit needs, subtracts, runs a bit-per-cycle restoring divider over 34
// quotient bits when the interval is positive, and loads the output register once any
// waiting result has been taken. The output register lets the back end finish the next
// item while a result waits on out_stall.
module calendar_interval_tick_counter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [11:0]                in_year,
  input  logic [3:0]                 in_month,
  input  logic [4:0]                 in_day,
  input  logic [4:0]                 in_hour,
  input  logic [5:0]                 in_minute,
  input  logic [5:0]                 in_second,
  input  logic [2:0]                 in_unit,
  input  logic [citc_pkg::PerW-1:0]  in_period,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [citc_pkg::TickW-1:0] out_tick_count
);

  logic           push;
  citc_pkg::job_t push_job;
  logic           pop;
  citc_pkg::job_t head;
  logic           q_full;
  logic           q_empty;

  citc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .in_hour   (in_hour),
    .in_minute (in_minute),
    .in_second (in_second),
    .in_unit   (in_unit),
    .in_period (in_period),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  citc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  citc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tick_count (out_tick_count)
  );

endmodule

// ===== test/calendar_interval_tick_counter_test.sv =====
`timescale 1ns / 1ps
module calendar_interval_tick_counter_test;

  localparam int CycleLimit = 400000;
  localparam int RandItems  = 800;
  localparam int HoldCycles = 300;
  localparam logic [2:0] UnitSpareLo = 3'd6;
  localparam logic [2:0] UnitSpareHi = 3'd7;

  typedef struct {
    logic                      cmd;
    logic [11:0]               year;
    logic [3:0]                month;
    logic [4:0]                day;
    logic [4:0]                hour;
    logic [5:0]                minute;
    logic [5:0]                second;
    logic [2:0]                unit;
    logic [citc_pkg::PerW-1:0] period;
    bit                        known;
    logic [31:0]               ticks;
  } stamp_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cmd;
  logic [11:0]                in_year;
  logic [3:0]                 in_month;
  logic [4:0]                 in_day;
  logic [4:0]                 in_hour;
  logic [5:0]                 in_minute;
  logic [5:0]                 in_second;
  logic [2:0]                 in_unit;
  logic [citc_pkg::PerW-1:0]  in_period;
  logic                       out_valid;
  logic                       out_stall;
  logic [citc_pkg::TickW-1:0] out_tick_count;

  logic [7:0] origin_year;
  logic [3:0] origin_month;
  logic [4:0] origin_day;
  logic [4:0] origin_hour;
  logic [5:0] origin_minute;
  logic [5:0] origin_second;

  logic [31:0] ticks_due [$];
  logic [31:0] due_ticks;
  int          cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int          errors;
  int          cycles;
  int          transfers_in;
  int          results_seen;
  int          stalled_offers;
  bit          calm;
  bit          hold_off_req;
  stamp_t      plan [25];

  calendar_interval_tick_counter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_hour       (in_hour),
    .in_minute     (in_minute),
    .in_second     (in_second),
    .in_unit       (in_unit),
    .in_period     (in_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tick_count(out_tick_count)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int year_slot(logic [11:0] yr);
    int off;
    off = int'(yr) - citc_pkg::YearBase;
    if (off < 0) off = 0;
    if (off > citc_pkg::YearSpan - 1) off = citc_pkg::YearSpan - 1;
    return off;
  endfunction

  function automatic longint leaps_upto(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_since_epoch(longint yo, longint mo, longint d);
    longint y;
    longint mc;
    longint r;
    y  = citc_pkg::YearBase + yo;
    mc = (mo < 1) ? 1 : ((mo > 12) ? 12 : mo);
    r  = yo * 365 + leaps_upto(y - 1) - leaps_upto(citc_pkg::YearBase - 1)
       + cum_days[mc - 1];
    if (mc > 2 && leap_year(y)) r += 1;
    return r + d - 1;
  endfunction

  function automatic longint count_units(logic [2:0] u, longint yo, longint mo, longint d,
                                         longint h, longint mi, longint s);
    longint days;
    days = days_since_epoch(yo, mo, d);
    case (u)
      citc_pkg::UNIT_SEC:   return ((days * 24 + h) * 60 + mi) * 60 + s;
      citc_pkg::UNIT_MIN:   return (days * 24 + h) * 60 + mi;
      citc_pkg::UNIT_HOUR:  return days * 24 + h;
      citc_pkg::UNIT_DAY:   return days;
      citc_pkg::UNIT_MONTH: return yo * 12 + mo - 1;
      default:              return yo;
    endcase
  endfunction

  function automatic logic [31:0] interval_ticks(stamp_t e);
    longint y1, m1, d1, h1, mi1, s1;
    longint diff, per, q;
    y1  = origin_year;
    m1  = origin_month;
    d1  = origin_day;
    h1  = origin_hour;
    mi1 = origin_minute;
    s1  = origin_second;
    case (e.unit)
      citc_pkg::UNIT_SEC: ;
      citc_pkg::UNIT_MIN:   if (s1 != 0) mi1 += 1;
      citc_pkg::UNIT_HOUR:  if (mi1 != 0 || s1 != 0) h1 += 1;
      citc_pkg::UNIT_DAY:   if (h1 != 0 || mi1 != 0 || s1 != 0) d1 += 1;
      citc_pkg::UNIT_MONTH: if (d1 != 1 || h1 != 0 || mi1 != 0 || s1 != 0) m1 += 1;
      default:    if (m1 != 1 || d1 != 1 || h1 != 0 || mi1 != 0 || s1 != 0) y1 += 1;
    endcase
    diff = count_units(e.unit, year_slot(e.year), e.month, e.day, e.hour, e.minute, e.second)
         - count_units(e.unit, y1, m1, d1, h1, mi1, s1);
    if (diff <= 0) return 32'd0;
    per = (e.period == '0) ? 1 : longint'(e.period);
    q   = diff / per;
    if (q > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic stamp_t mk(logic c, int yr, int mo, int d, int h, int mi, int s,
                                logic [2:0] u, logic [citc_pkg::PerW-1:0] per, bit known,
                                logic [31:0] ticks);
    stamp_t t;
    t.cmd    = c;
    t.year   = yr[11:0];
    t.month  = mo[3:0];
    t.day    = d[4:0];
    t.hour   = h[4:0];
    t.minute = mi[5:0];
    t.second = s[5:0];
    t.unit   = u;
    t.period = per;
    t.known  = known;
    t.ticks  = ticks;
    return t;
  endfunction

  function automatic stamp_t pick_stamp(bit raw);
    stamp_t t;
    int     k;
    t.known = 1'b0;
    t.ticks = '0;
    if (raw) begin
      t.cmd    = 1'($urandom);
      t.year   = 12'($urandom);
      t.month  = 4'($urandom);
      t.day    = 5'($urandom);
      t.hour   = 5'($urandom);
      t.minute = 6'($urandom);
      t.second = 6'($urandom);
      t.unit   = 3'($urandom);
    end else begin
      t.cmd    = citc_pkg::CmdStart;
      t.year   = $urandom_range(0, 1)
               ? 12'(citc_pkg::YearBase + origin_year + $urandom_range(0, 2))
               : 12'($urandom_range(citc_pkg::YearBase,
                                    citc_pkg::YearBase + citc_pkg::YearSpan - 1));
      t.month  = 4'($urandom_range(1, 12));
      t.day    = 5'($urandom_range(1, 31));
      t.hour   = 5'($urandom_range(0, 23));
      t.minute = 6'($urandom_range(0, 59));
      t.second = 6'($urandom_range(0, 59));
      t.unit   = 3'($urandom_range(0, 5));
      k = $urandom_range(0, 6);
      if (k >= 1) t.second = '0;
      if (k >= 2) t.minute = '0;
      if (k >= 3) t.hour = '0;
      if (k >= 4) t.day = 5'd1;
      if (k >= 5) t.month = 4'd1;
    end
    case ($urandom_range(0, 9))
      0:          t.period = '0;
      1, 2, 3, 4: t.period = citc_pkg::PerW'($urandom_range(1, 4));
      5, 6, 7:    t.period = citc_pkg::PerW'($urandom_range(1, 5000));
      default:    t.period = citc_pkg::PerW'($urandom);
    endcase
    return t;
  endfunction

  task automatic offer(input stamp_t t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_cmd    = t.cmd;
    in_year   = t.year;
    in_month  = t.month;
    in_day    = t.day;
    in_hour   = t.hour;
    in_minute = t.minute;
    in_second = t.second;
    in_unit   = t.unit;
    in_period = t.period;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      stalled_offers++;
      @(posedge clk);
    end
    if (t.cmd == citc_pkg::CmdStart) begin
      origin_year   = 8'(year_slot(t.year));
      origin_month  = t.month;
      origin_day    = t.day;
      origin_hour   = t.hour;
      origin_minute = t.minute;
      origin_second = t.second;
    end else begin
      ticks_due.push_back(t.known ? t.ticks : interval_ticks(t));
    end
    transfers_in++;
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("calendar_interval_tick_counter_test: done, errors");
      $finish;
    end
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (ticks_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected tick count %0d", out_tick_count));
      end else begin
        due_ticks = ticks_due.pop_front();
        results_seen++;
        if (out_tick_count !== due_ticks)
          flag_mismatch($sformatf("tick count %0d, want %0d", out_tick_count, due_ticks));
      end
    end
  end

  initial begin
    int     random_sent;
    int     ends;
    bit     hold_done;
    stamp_t t;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = citc_pkg::CmdStart;
    in_year   = '0;
    in_month  = '0;
    in_day    = '0;
    in_hour   = '0;
    in_minute = '0;
    in_second = '0;
    in_unit   = '0;
    in_period = '0;
    origin_year   = '0;
    origin_month  = '0;
    origin_day    = '0;
    origin_hour   = '0;
    origin_minute = '0;
    origin_second = '0;
    random_sent = 0;
    hold_done   = 1'b0;

    plan[0]  = mk(citc_pkg::CmdEnd,   1970,  1,  1,  0,  0,  0, citc_pkg::UNIT_YEAR,
                  1, 1, 32'd0);
    plan[1]  = mk(citc_pkg::CmdEnd,   1970,  1,  1,  0,  0,  0, citc_pkg::UNIT_SEC,
                  1, 1, 32'd86400);
    plan[2]  = mk(citc_pkg::CmdStart, 1970,  1,  1,  0,  0,  0, citc_pkg::UNIT_SEC,
                  1, 0, 32'd0);
    plan[3]  = mk(citc_pkg::CmdEnd,   2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_SEC,
                  1, 1, 32'd4102444799);
    plan[4]  = mk(citc_pkg::CmdEnd,   2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_SEC,
                  0, 1, 32'd4102444799);
    plan[5]  = mk(citc_pkg::CmdEnd,   2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_SEC,
                  2147483647, 1, 32'd1);
    plan[6]  = mk(citc_pkg::CmdEnd,   2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_YEAR,
                  1, 1, 32'd129);
    plan[7]  = mk(citc_pkg::CmdEnd,   4095, 12, 31,  0,  0,  0, citc_pkg::UNIT_MONTH,
                  1, 1, 32'd1559);
    plan[8]  = mk(citc_pkg::CmdStart,    0, 15, 31, 31, 63, 63, citc_pkg::UNIT_SEC,
                  1, 0, 32'd0);
    plan[9]  = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, citc_pkg::UNIT_SEC,
                  7, 0, 32'd0);
    plan[10] = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, citc_pkg::UNIT_MIN,
                  1, 0, 32'd0);
    plan[11] = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, citc_pkg::UNIT_HOUR,
                  3, 0, 32'd0);
    plan[12] = mk(citc_pkg::CmdEnd,   2025,  0,  0, 31, 63, 63, citc_pkg::UNIT_DAY,
                  1, 0, 32'd0);
    plan[13] = mk(citc_pkg::CmdEnd,   2025, 15, 15, 12, 30, 45, citc_pkg::UNIT_MONTH,
                  1, 0, 32'd0);
    plan[14] = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, citc_pkg::UNIT_YEAR,
                  1, 0, 32'd0);
    plan[15] = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, UnitSpareLo,
                  1, 0, 32'd0);
    plan[16] = mk(citc_pkg::CmdEnd,   2025,  6, 15, 12, 30, 45, UnitSpareHi,
                  2, 0, 32'd0);
    plan[17] = mk(citc_pkg::CmdStart, 2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_SEC,
                  1, 0, 32'd0);
    plan[18] = mk(citc_pkg::CmdEnd,   1970,  1,  1,  0,  0,  0, citc_pkg::UNIT_DAY,
                  1, 1, 32'd0);
    plan[19] = mk(citc_pkg::CmdEnd,   2099, 12, 31, 23, 59, 59, citc_pkg::UNIT_YEAR,
                  1, 1, 32'd0);
    plan[20] = mk(citc_pkg::CmdStart, 2000,  3,  0, 12,  0,  0, citc_pkg::UNIT_SEC,
                  1, 0, 32'd0);
    plan[21] = mk(citc_pkg::CmdEnd,   2000,  3,  1,  0,  0,  0, citc_pkg::UNIT_DAY,
                  1, 0, 32'd0);
    plan[22] = mk(citc_pkg::CmdEnd,   2001,  0,  0,  0,  0,  0, citc_pkg::UNIT_HOUR,
                  5, 0, 32'd0);
    plan[23] = mk(citc_pkg::CmdStart, 2024,  5,  1,  0,  0,  0, citc_pkg::UNIT_SEC,
                  1, 0, 32'd0);
    plan[24] = mk(citc_pkg::CmdEnd,   2024,  7,  1,  0,  0,  0, citc_pkg::UNIT_MONTH,
                  1, 1, 32'd2);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) offer(plan[i]);

    while (random_sent < RandItems) begin
      if (!hold_done && random_sent >= 200) begin
        hold_done    = 1'b1;
        hold_off_req = 1'b1;
      end
      if (random_sent >= RandItems - 100) calm = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        offer(pick_stamp(1'b1));
        random_sent++;
      end else begin
        offer(pick_stamp(1'b0));
        random_sent++;
        ends = $urandom_range(1, 3);
        repeat (ends) begin
          t = pick_stamp(1'b0);
          t.cmd = citc_pkg::CmdEnd;
          offer(t);
          random_sent++;
        end
      end
    end
    in_valid = 1'b0;

    while (ticks_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d transfers in, %0d tick counts checked, %0d cycles of input held back",
             transfers_in, results_seen, stalled_offers);
    $display("all six units and spare unit codes, clamped years, overflowed fields, period 0");
    if (errors == 0) begin
      $display("calendar_interval_tick_counter_test: done, clean");
    end else begin
      $display("calendar_interval_tick_counter_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/citc_pkg.sv
hdl/citc_front.sv
hdl/citc_queue.sv
hdl/citc_back.sv
hdl/calendar_interval_tick_counter.sv
test/calendar_interval_tick_counter_test.sv
